// File: sv/dmc_pkg.sv
// shared types, codes and command/status structs for the direct-mapped cache hit model
`timescale 1ns / 1ps
`default_nettype none

package dmc_pkg;

    localparam int DEF_MAX_SET_BITS = 8;

    localparam int ADDR_W      = 64;
    localparam int COUNT_W     = 32;
    localparam int SET_BITS_W  = 4;
    localparam int BLK_BITS_W  = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;

    // access kinds
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_STORE  = 2'd1;
    localparam logic [1:0] REQ_MODIFY = 2'd2;
    localparam logic [1:0] REQ_FETCH  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;

    localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 4'd1;
    localparam logic [BLK_BITS_W-1:0] BLK_BITS_RST = 6'd1;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic [1:0]         hit_now;
        logic               miss_now;
        logic               evict_now;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] miss_total;
        logic [COUNT_W-1:0] evict_total;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic clr_write;
        logic load_req;
        logic lookup;
        logic commit;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: sv/direct_mapped_cache_hit_model.sv
// top level of the direct-mapped cache hit model
//
//  channel   direction  handshake                    payload
//  ------    ---------  ---------------------------  ---------------------------------
//  req       in         i_req_valid / o_req_stall    dmc_pkg::t_req (req_type, address)
//  rsp       out        o_rsp_valid / i_rsp_stall    dmc_pkg::t_rsp (per-access + totals)
//  cfg       in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
//  - each request passes through accept, address split + tag read and compare + fill,
//    steps set by the single registered read port of the tag memory
//  - a request whose result cannot leave waits in compare until the output register frees
//  - after reset a clearing pass writes every line invalid with requests stalled;
//    configuration writes are taken throughout
//  - reset is synchronous and active low; counters and set/block bits return to defaults
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_cache_hit_model #(
    parameter int MAX_SET_BITS = dmc_pkg::DEF_MAX_SET_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request channel
    input  wire logic                           i_req_valid,
    output logic                                o_req_stall,
    input  wire dmc_pkg::t_req                  i_req,
    // result channel
    output logic                                o_rsp_valid,
    input  wire logic                           i_rsp_stall,
    output dmc_pkg::t_rsp                       o_rsp,
    // configuration write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [dmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dmc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    dmc_pkg::t_dp_cmd cmd;
    dmc_pkg::t_dp_sts sts;

    // configuration is always accepted; the user writes it only while idle
    assign o_cfg_ready = 1'b1;

    // sequencer: clear pass, accept, lookup, commit
    dmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // tag store, compare and counters
    dmc_datapath #(
        .MAX_SET_BITS (MAX_SET_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp),
        .o_rsp_valid (o_rsp_valid)
    );

endmodule

`default_nettype wire

// File: sv/dmc_ctrl.sv
// sequencing state machine for the direct-mapped cache hit model
`timescale 1ns / 1ps
`default_nettype none

module dmc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_stall,
    input  wire dmc_pkg::t_dp_sts i_sts,
    output dmc_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_CMP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_ADDR;
                end
            end
            S_ADDR: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_CMP;
            end
            S_CMP: begin
                // wait here until the result register can take the outcome
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_stall <= 1'b1;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_req_stall = r_stall;

`ifndef SYNTH
    a_stall_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_req_stall)
        else $error("request stalled while idle");

    a_accept_goes_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> (r_state == S_ADDR))
        else $error("accepted request did not start lookup");

    a_lookup_then_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.lookup |=> (r_state == S_CMP))
        else $error("lookup not followed by compare");
`endif

endmodule

`default_nettype wire

// File: sv/dmc_datapath.sv
// address split, tag memory, compare and saturating counters
`timescale 1ns / 1ps
`default_nettype none

module dmc_datapath #(
    parameter int MAX_SET_BITS = dmc_pkg::DEF_MAX_SET_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire dmc_pkg::t_dp_cmd               i_cmd,
    output dmc_pkg::t_dp_sts                    o_sts,
    input  wire dmc_pkg::t_req                  i_req,
    input  wire logic                           i_cfg_we,
    input  wire logic [dmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_rsp_stall,
    output dmc_pkg::t_rsp                       o_rsp,
    output logic                                o_rsp_valid
);

    localparam int IDX_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int DEPTH  = 2 ** IDX_W;
    localparam int SB_W   = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
    localparam int AW     = dmc_pkg::ADDR_W;
    localparam int CW     = dmc_pkg::COUNT_W;
    localparam int SHW    = 7;
    localparam int WORD_W = AW + 1;

    // configuration
    logic [dmc_pkg::SET_BITS_W-1:0] r_set_bits;
    logic [dmc_pkg::BLK_BITS_W-1:0] r_block_bits;

    // request and lookup registers
    dmc_pkg::t_req     r_req;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic [AW-1:0]     r_tag;
    logic [AW-1:0]     n_tag;
    logic [WORD_W-1:0] r_rdata;
    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [IDX_W-1:0]  r_clr_addr;

    logic [SB_W-1:0]   sb;
    logic [SHW-1:0]    tag_shift;
    logic [AW-1:0]     blk_shifted;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    logic              is_access;
    logic              is_modify;
    logic              line_valid;
    logic              match;
    logic [1:0]        hits;
    logic              miss;
    logic              evict;

    logic [CW-1:0]     r_hit_cnt;
    logic [CW-1:0]     r_miss_cnt;
    logic [CW-1:0]     r_evict_cnt;
    logic [CW-1:0]     n_hit_cnt;
    logic [CW-1:0]     n_miss_cnt;
    logic [CW-1:0]     n_evict_cnt;
    logic [CW:0]       hit_sum;
    logic [CW:0]       miss_sum;
    logic [CW:0]       evict_sum;

    dmc_pkg::t_rsp     r_rsp;
    logic              r_rsp_valid;

    // set index width clamps at the memory's index width
    always_comb begin
        if (int'(r_set_bits) > MAX_SET_BITS) begin
            sb = SB_W'(MAX_SET_BITS);
        end else begin
            sb = SB_W'(r_set_bits);
        end
        tag_shift   = SHW'(sb) + SHW'(r_block_bits);
        blk_shifted = r_req.address >> r_block_bits;
        for (int j = 0; j < IDX_W; j++) begin
            n_idx[j] = blk_shifted[j] & (j < int'(sb));
        end
        // tag_shift never reaches 128, so bit 6 flags a shift of 64 or more
        n_tag = tag_shift[6] ? '0 : (r_req.address >> tag_shift[5:0]);
    end

    // outcome of the lookup
    always_comb begin
        is_access  = (r_req.req_type != dmc_pkg::REQ_FETCH);
        is_modify  = (r_req.req_type == dmc_pkg::REQ_MODIFY);
        line_valid = r_rdata[AW];
        match      = line_valid && (r_rdata[AW-1:0] == r_tag);
        hits       = 2'd0;
        miss       = 1'b0;
        evict      = 1'b0;
        if (is_access) begin
            if (match) begin
                hits = is_modify ? 2'd2 : 2'd1;
            end else begin
                hits  = is_modify ? 2'd1 : 2'd0;
                miss  = 1'b1;
                evict = line_valid;
            end
        end
        hit_sum     = {1'b0, r_hit_cnt} + (CW+1)'(hits);
        miss_sum    = {1'b0, r_miss_cnt} + (CW+1)'(miss);
        evict_sum   = {1'b0, r_evict_cnt} + (CW+1)'(evict);
        n_hit_cnt   = hit_sum[CW] ? '1 : hit_sum[CW-1:0];
        n_miss_cnt  = miss_sum[CW] ? '1 : miss_sum[CW-1:0];
        n_evict_cnt = evict_sum[CW] ? '1 : evict_sum[CW-1:0];
    end

    // memory write port: clearing pass after reset, fill on a miss
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = {1'b1, r_tag};
        if (i_cmd.clr_write) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (i_cmd.commit && is_access && !match) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.lookup) begin
            r_rdata <= r_mem[n_idx];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (i_cmd.lookup) begin
            r_idx <= n_idx;
            r_tag <= n_tag;
        end
        if (i_cmd.commit) begin
            r_rsp.hit_now     <= hits;
            r_rsp.miss_now    <= miss;
            r_rsp.evict_now   <= evict;
            r_rsp.hit_total   <= n_hit_cnt;
            r_rsp.miss_total  <= n_miss_cnt;
            r_rsp.evict_total <= n_evict_cnt;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= dmc_pkg::SET_BITS_RST;
            r_block_bits <= dmc_pkg::BLK_BITS_RST;
            r_clr_addr   <= '0;
            r_hit_cnt    <= '0;
            r_miss_cnt   <= '0;
            r_evict_cnt  <= '0;
            r_rsp_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dmc_pkg::CFG_SET_BITS: begin
                        r_set_bits <= i_cfg_data[dmc_pkg::SET_BITS_W-1:0];
                    end
                    dmc_pkg::CFG_BLOCK_BITS: begin
                        r_block_bits <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clr_write) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.commit) begin
                r_hit_cnt   <= n_hit_cnt;
                r_miss_cnt  <= n_miss_cnt;
                r_evict_cnt <= n_evict_cnt;
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clr_last = (r_clr_addr == IDX_W'(DEPTH - 1));
    assign o_sts.out_free = !r_rsp_valid || !i_rsp_stall;
    assign o_rsp          = r_rsp;
    assign o_rsp_valid    = r_rsp_valid;

`ifndef SYNTH
    a_commit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_rsp_valid || !i_rsp_stall))
        else $error("result overwritten while stalled");

    a_evict_implies_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && r_rsp.evict_now) |-> r_rsp.miss_now)
        else $error("eviction without miss");

    a_hit_count_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_hit_cnt >= $past(r_hit_cnt)))
        else $error("hit counter wrapped");

    a_hits_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid |-> (r_rsp.hit_now != 2'd3))
        else $error("hit count out of range");
`endif

endmodule

`default_nettype wire

// File: test/direct_mapped_cache_hit_checker.sv
// checker that predicts cache access outcomes and compares them with the block's results
`timescale 1ns / 1ps

module direct_mapped_cache_hit_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    input  logic                                i_req_stall,
    input  dmc_pkg::t_req                       i_req,
    input  logic                                i_rsp_valid,
    input  logic                                i_rsp_stall,
    input  dmc_pkg::t_rsp                       i_rsp,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [dmc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dmc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked,
    output logic [dmc_pkg::COUNT_W-1:0]         o_hits,
    output logic [dmc_pkg::COUNT_W-1:0]         o_misses,
    output logic [dmc_pkg::COUNT_W-1:0]         o_evictions
);
    import dmc_pkg::*;

    localparam int MAX_SB     = DEF_MAX_SET_BITS;
    localparam int LINES      = 2 ** DEF_MAX_SET_BITS;

    logic [SET_BITS_W-1:0] set_bits_q;
    logic [BLK_BITS_W-1:0] block_bits_q;
    logic                  line_live [LINES];
    logic [ADDR_W-1:0]     line_tag [LINES];
    logic [COUNT_W-1:0]    hit_count;
    logic [COUNT_W-1:0]    miss_count;
    logic [COUNT_W-1:0]    evict_count;
    t_rsp                  outcome_q [$];
    int                    fails    = 0;
    int                    checked  = 0;

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] acc,
                                                   input logic [COUNT_W-1:0] inc);
        logic [COUNT_W:0] sum;
        sum = {1'b0, acc} + {1'b0, inc};
        return sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
    endfunction

    // tag lookup and fill for one access, updates the shadow store
    task automatic predict_access(input t_req r, output t_rsp res);
        int unsigned       sb;
        int unsigned       bb;
        int unsigned       shift;
        int unsigned       idx;
        logic [ADDR_W-1:0] set_mask;
        logic [ADDR_W-1:0] tag;
        logic [1:0]        hits;
        logic              miss;
        logic              evict;
        sb       = (set_bits_q > MAX_SB) ? MAX_SB : set_bits_q;
        bb       = block_bits_q;
        shift    = sb + bb;
        set_mask = (64'd1 << sb) - 64'd1;
        idx      = int'((r.address >> bb) & set_mask);
        tag      = (shift >= ADDR_W) ? '0 : (r.address >> shift);
        hits     = 2'd0;
        miss     = 1'b0;
        evict    = 1'b0;
        if (r.req_type != REQ_FETCH) begin
            if (line_live[idx] && line_tag[idx] == tag) begin
                hits = (r.req_type == REQ_MODIFY) ? 2'd2 : 2'd1;
            end else begin
                miss  = 1'b1;
                evict = line_live[idx];
                if (r.req_type == REQ_MODIFY) begin
                    hits = 2'd1;
                end
                line_live[idx] = 1'b1;
                line_tag[idx]  = tag;
            end
            hit_count   = sat_add(hit_count, COUNT_W'(hits));
            miss_count  = sat_add(miss_count, COUNT_W'(miss));
            evict_count = sat_add(evict_count, COUNT_W'(evict));
        end
        res.hit_now     = hits;
        res.miss_now    = miss;
        res.evict_now   = evict;
        res.hit_total   = hit_count;
        res.miss_total  = miss_count;
        res.evict_total = evict_count;
    endtask

    task automatic check_field(input string field_name, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field_name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rsp want;
        t_rsp next_outcome;
        if (!i_rst_n) begin
            set_bits_q   = SET_BITS_RST;
            block_bits_q = BLK_BITS_RST;
            foreach (line_live[i]) line_live[i] = 1'b0;
            hit_count   = '0;
            miss_count  = '0;
            evict_count = '0;
            outcome_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SET_BITS:   set_bits_q = i_cfg_data[SET_BITS_W-1:0];
                    CFG_BLOCK_BITS: block_bits_q = i_cfg_data[BLK_BITS_W-1:0];
                    default: ;
                endcase
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (outcome_q.size() == 0) begin
                    fails++;
                    $display("%0t: result with no request outstanding, expected none, actual %h",
                             $time, i_rsp);
                end else begin
                    want = outcome_q.pop_front();
                    check_field("hit_now", COUNT_W'(want.hit_now), COUNT_W'(i_rsp.hit_now));
                    check_field("miss_now", COUNT_W'(want.miss_now), COUNT_W'(i_rsp.miss_now));
                    check_field("evict_now", COUNT_W'(want.evict_now),
                                COUNT_W'(i_rsp.evict_now));
                    check_field("hit_total", want.hit_total, i_rsp.hit_total);
                    check_field("miss_total", want.miss_total, i_rsp.miss_total);
                    check_field("evict_total", want.evict_total, i_rsp.evict_total);
                    checked++;
                end
            end
            if (i_req_valid && !i_req_stall) begin
                predict_access(i_req, next_outcome);
                outcome_q.push_back(next_outcome);
            end
        end
        o_fail_count <= fails;
        o_pending    <= outcome_q.size();
        o_checked    <= checked;
        o_hits       <= hit_count;
        o_misses     <= miss_count;
        o_evictions  <= evict_count;
    end

endmodule

// File: test/direct_mapped_cache_hit_model_tb.sv
// testbench top: drives requests and geometry writes into the cache hit model, gives the verdict
`timescale 1ns / 1ps

module direct_mapped_cache_hit_model_tb;
    import dmc_pkg::*;

    // register indexes the block does not implement, written to check they are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 222;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    t_req                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    t_rsp                  rsp;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int                    fail_count;
    int                    pending;
    int                    checked;
    logic [COUNT_W-1:0]    hit_sum;
    logic [COUNT_W-1:0]    miss_sum;
    logic [COUNT_W-1:0]    evict_sum;

    // stimulus state: burst phases turn off idling on both sides
    bit                    no_idle = 1'b0;
    int unsigned           cur_sb  = 1;
    int unsigned           cur_bb  = 1;
    int unsigned           sent    = 0;
    int unsigned           shapes  = 1;
    logic [ADDR_W-1:0]     addr_pool [16];

    always #2 clk = ~clk;

    direct_mapped_cache_hit_model i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    direct_mapped_cache_hit_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_req        (req),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_stall  (rsp_stall),
        .i_rsp        (rsp),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hit_sum),
        .o_misses     (miss_sum),
        .o_evictions  (evict_sum)
    );

    // one access request; valid stays high across back-to-back requests
    task automatic issue(input logic [1:0] kind, input logic [ADDR_W-1:0] addr);
        int unsigned gap;
        t_req        next_req;
        gap               = no_idle ? 0 : $urandom_range(0, 15);
        next_req.req_type = kind;
        next_req.address  = addr;
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= next_req;
        // accepted at the first edge with stall low
        do @(posedge clk); while (req_stall);
        sent++;
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // new set/offset split, then a write to an unused index that must change nothing
    task automatic set_geometry(input logic [CFG_DATA_W-1:0] sb_data,
                                input logic [CFG_DATA_W-1:0] bb_data);
        write_reg(CFG_SET_BITS, sb_data);
        write_reg(CFG_BLOCK_BITS, bb_data);
        write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        cur_sb = sb_data[SET_BITS_W-1:0];
        cur_bb = bb_data[BLK_BITS_W-1:0];
        shapes++;
    endtask

    // wait until every outstanding request has produced its result
    task automatic settle();
        req_valid <= 1'b0;
        // let the pending count take in the last accepted request before it is polled
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // pipeline is 3 deep; then idle before touching registers
        repeat (4) @(posedge clk);
    endtask

    // result side: random stall before each result, none in burst phases
    initial begin : rsp_pacing
        int unsigned hold;
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 15);
            if (hold != 0) begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!(rsp_valid && rst_n));
        end
    end

    initial begin : stimulus
        int                phase;
        int unsigned       roll;
        int unsigned       slot;
        int unsigned       eff_sb;
        logic [ADDR_W-1:0] fresh;
        logic [ADDR_W-1:0] offs_mask;
        logic [ADDR_W-1:0] addr;
        logic [1:0]        kind;

        foreach (addr_pool[i]) addr_pool[i] = {$urandom, $urandom};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset split: one set bit, one offset bit -> set = addr[1], tag = addr >> 2
        // requests wait out the clearing pass through the stall
        issue(REQ_LOAD, 64'd0);                    // cold miss
        issue(REQ_LOAD, 64'd0);                    // hit
        issue(REQ_STORE, 64'd1);                   // other byte of the same block, hit
        issue(REQ_MODIFY, 64'd0);                  // two hits
        issue(REQ_LOAD, 64'd2);                    // cold miss in the other set
        issue(REQ_LOAD, 64'd4);                    // conflicting tag, miss and eviction
        issue(REQ_MODIFY, 64'd0);                  // miss, hit and eviction
        issue(REQ_FETCH, '1);                      // fetch leaves everything alone
        issue(REQ_STORE, '1);                      // miss with eviction
        issue(REQ_LOAD, '1);                       // hit
        settle();

        // oversized set count clamps to 8, offset of 63 makes the tag zero;
        // lines keep their contents across the change
        set_geometry(6'h3F, 6'd63);
        issue(REQ_LOAD, 64'd0);                    // set 0 still holds tag 0, hit
        issue(REQ_LOAD, 64'h8000_0000_0000_0000);  // set 1 held an old tag, eviction
        issue(REQ_MODIFY, '1);                     // two hits
        settle();

        // no set bits and no offset: one line, tag is the full address
        set_geometry(6'd0, 6'd0);
        issue(REQ_STORE, 64'd0);
        issue(REQ_LOAD, '1);
        issue(REQ_MODIFY, 64'h5555_5555_5555_5555);
        issue(REQ_FETCH, 64'd0);
        settle();

        // full set index above a 32-bit offset
        set_geometry(6'd8, 6'd32);
        issue(REQ_LOAD, 64'h0000_00FF_0000_0000);
        issue(REQ_STORE, '1);
        issue(REQ_LOAD, 64'h0000_00AB_1234_5678);
        settle();

        // set and offset bits reach exactly 64: tag is zero, set 0xAB already holds it
        set_geometry(6'd8, 6'd56);
        issue(REQ_LOAD, 64'hAB00_0000_0000_0000);
        settle();

        // random phases: extreme splits first, then random ones with mostly small offsets
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_geometry(6'd0, 6'd0);
                1: set_geometry(6'd8, 6'd63);
                2: set_geometry(6'h3F, 6'd4);
                3: set_geometry(6'd2, 6'd0);
                default: set_geometry(CFG_DATA_W'($urandom_range(0, 63)),
                                      ($urandom_range(0, 3) == 0) ?
                                      CFG_DATA_W'($urandom_range(0, 63)) :
                                      CFG_DATA_W'($urandom_range(0, 10)));
            endcase
            no_idle = (phase == 2 || phase == 5);
            repeat (PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 10) begin
                    kind = REQ_FETCH;
                end else if (roll < 40) begin
                    kind = REQ_LOAD;
                end else if (roll < 70) begin
                    kind = REQ_STORE;
                end else begin
                    kind = REQ_MODIFY;
                end
                // addresses mostly revisit a small pool so lines get reused and evicted
                fresh     = {$urandom, $urandom};
                slot      = $urandom_range(0, 15);
                eff_sb    = (cur_sb > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : cur_sb;
                offs_mask = (64'd1 << cur_bb) - 64'd1;
                roll      = $urandom_range(0, 99);
                if (roll < 45) begin
                    // same block, random byte within it
                    addr = addr_pool[slot] ^ (fresh & offs_mask);
                end else if (roll < 65 && cur_bb + eff_sb < ADDR_W) begin
                    // same set, one tag bit flipped
                    addr = addr_pool[slot] ^ (64'd1 << $urandom_range(cur_bb + eff_sb, 63));
                end else if (roll < 80) begin
                    addr_pool[slot] = fresh;
                    addr            = fresh;
                end else if (roll < 90) begin
                    addr = ADDR_W'($urandom_range(0, 255));
                end else begin
                    addr = fresh;
                end
                issue(kind, addr);
            end
            settle();
            no_idle = 1'b0;
        end

        // let any stray result show up before the verdict
        repeat (12) @(posedge clk);
        $display("covered %0d requests over %0d cache geometries, %0d results checked",
                 sent, shapes, checked);
        $display("predicted totals: %0d hits, %0d misses, %0d evictions",
                 hit_sum, miss_sum, evict_sum);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #2_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, pending);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
